// ===== design/lst_pkg.sv =====
// Shared types and constants for the lease semaphore table.
package lst_pkg;

    // Default sizes of the table.
    localparam int NUM_TYPES_DEF  = 8;
    localparam int ID_BITS_DEF    = 48;
    localparam int TIMER_BITS_DEF = 18;

    // Fixed field widths of the streaming payloads and registers.
    localparam int CMD_W     = 2;
    localparam int TYPE_W    = 8;
    localparam int REQ_ID_W  = 48;
    localparam int STATUS_W  = 2;
    localparam int HOLD_W    = 18;
    localparam int LTYPE_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 64;
    localparam int M_DATA_W  = 16;

    // Register reset values.
    localparam logic [HOLD_W-1:0]  HOLD_RST      = HOLD_W'(3 * 1000);
    localparam logic [HOLD_W-1:0]  LONG_HOLD_RST = HOLD_W'(135 * 1000);
    localparam logic [LTYPE_W-1:0] LONG_TYPE_RST = '0;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD_TYPE  = 2'd2;

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_NONE    = 2'd3
    } lst_cmd_t;

    // Answer codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BUSY      = 2'd1,
        ST_NOT_OWNER = 2'd2,
        ST_INVALID   = 2'd3
    } lst_status_t;

    // Per-slot control from the request decoder.
    typedef struct packed {
        logic acquire;
        logic release_req;
        logic tick;
    } lst_slot_ctrl_t;

    // Per-slot status back to the request decoder.
    typedef struct packed {
        logic held;
        logic owner_match;
    } lst_slot_stat_t;

endpackage

// ===== design/lst_lock_slot.sv =====
// One lock of the table: held flag, owner identity and lease countdown.
module lst_lock_slot
    import lst_pkg::*;
#(
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lst_slot_ctrl_t        ctrl,
    input  logic [ID_BITS-1:0]    req_id,
    input  logic [TIMER_BITS-1:0] lease_len,
    output lst_slot_stat_t        stat
);

    logic                  held_reg,  held_next;
    logic [ID_BITS-1:0]    owner_reg, owner_next;
    logic [TIMER_BITS-1:0] lease_reg, lease_next;
    logic                  owner_match;

    assign owner_match      = (owner_reg == req_id);
    assign stat.held        = held_reg;
    assign stat.owner_match = owner_match;

    // Acquire, release and lease countdown.
    always_comb begin
        held_next  = held_reg;
        owner_next = owner_reg;
        lease_next = lease_reg;
        if (ctrl.acquire && !held_reg) begin
            held_next  = 1'b1;
            owner_next = req_id;
            lease_next = lease_len;
        end else if (ctrl.release_req && owner_match) begin
            held_next  = 1'b0;
            owner_next = '0;
            lease_next = '0;
        end else if (ctrl.tick && held_reg && (lease_reg != '0)) begin
            if (lease_reg == TIMER_BITS'(1)) begin
                held_next  = 1'b0;
                owner_next = '0;
                lease_next = '0;
            end else begin
                lease_next = lease_reg - TIMER_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            owner_reg <= '0;
            lease_reg <= '0;
        end else begin
            held_reg  <= held_next;
            owner_reg <= owner_next;
            lease_reg <= lease_next;
        end
    end

    // A free lock keeps no owner and no running lease.
    a_free_is_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_reg |-> (owner_reg == '0) && (lease_reg == '0))
        else $error("free lock holds owner or lease");

    // An acquire of a free lock takes it.
    a_acquire_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.acquire && !held_reg |=> held_reg && (owner_reg == $past(req_id)))
        else $error("acquire of free lock did not take it");

    // The last tick of a lease frees the lock.
    a_expiry_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.tick && held_reg && (lease_reg == TIMER_BITS'(1)) |=> !held_reg)
        else $error("expired lease did not free lock");

endmodule

// ===== design/lease_semaphore_table_unit.sv =====
// Top level of the lease semaphore table: request decode, lock slots and result register.
//
// A table of NUM_TYPES ownership locks with lease timeouts. Each request
// (acquire, release or one-millisecond tick) is accepted on its handshake: the
// lock slots and the result register both update at the edge that accepts
// it. One request is taken every cycle while the result register is empty or
// its answer is being taken in the same cycle, so the block sustains one item
// per cycle; the result register alone sets that figure. Acquire and release
// give one answer each; ticks and command 3 give none, and lease expiries are
// silent. Configuration writes take effect at the next edge.
module lease_semaphore_table_unit
    import lst_pkg::*;
#(
    parameter int NUM_TYPES  = NUM_TYPES_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HOLD_W-1:0]    cfg_wdata,
    // Request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // command[1:0], lock_type[9:2], requester_id[57:10]
    // Answer channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // status[1:0], echo_type[9:2]
    output logic                 m_tuser    // was_acquire[0]
);

    localparam logic [32:0] TimerMaxWide = (33'd1 << TIMER_BITS) - 33'd1;
    localparam logic [TIMER_BITS-1:0] TimerMax = '1;

    // Configuration registers
    logic [HOLD_W-1:0]  hold_ticks_reg;
    logic [HOLD_W-1:0]  long_hold_ticks_reg;
    logic [LTYPE_W-1:0] long_hold_type_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg      <= HOLD_RST;
            long_hold_ticks_reg <= LONG_HOLD_RST;
            long_hold_type_reg  <= LONG_TYPE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HOLD_TICKS:      hold_ticks_reg      <= cfg_wdata;
                REG_LONG_HOLD_TICKS: long_hold_ticks_reg <= cfg_wdata;
                REG_LONG_HOLD_TYPE:  long_hold_type_reg  <= cfg_wdata[LTYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // Request fields; no transaction is taken while reset is held.
    lst_cmd_t           cmd;
    logic [TYPE_W-1:0]  lock_type;
    logic [ID_BITS-1:0] req_id;
    logic               accept;
    logic               type_valid;

    assign cmd        = lst_cmd_t'(s_tdata[1:0]);
    assign lock_type  = s_tdata[9:2];
    assign req_id     = ID_BITS'(s_tdata[57:10]);
    assign s_tready   = aresetn && (!m_tvalid || m_tready);
    assign accept     = s_tvalid && s_tready;
    assign type_valid = (lock_type != '0) && (32'(lock_type) <= 32'(NUM_TYPES));

    // Lease length for this type, zero taken as one and clipped to the counter.
    logic              use_long;
    logic [HOLD_W-1:0] len_raw;
    logic [TIMER_BITS-1:0] lease_len;

    always_comb begin
        use_long = (long_hold_type_reg != '0) && ({1'b0, long_hold_type_reg} == lock_type);
        len_raw  = use_long ? long_hold_ticks_reg : hold_ticks_reg;
        if (len_raw == '0) begin
            lease_len = TIMER_BITS'(1);
        end else if (33'(len_raw) > TimerMaxWide) begin
            lease_len = TimerMax;
        end else begin
            lease_len = TIMER_BITS'(len_raw);
        end
    end

    // Lock slots
    lst_slot_ctrl_t slot_ctrl [NUM_TYPES];
    lst_slot_stat_t slot_stat [NUM_TYPES];

    for (genvar i = 0; i < NUM_TYPES; i++) begin : g_slot
        logic sel;
        assign sel = (32'(lock_type) == 32'(i + 1));
        assign slot_ctrl[i].acquire     = accept && (cmd == CMD_ACQUIRE) && sel;
        assign slot_ctrl[i].release_req = accept && (cmd == CMD_RELEASE) && sel;
        assign slot_ctrl[i].tick        = accept && (cmd == CMD_TICK);

        lst_lock_slot #(
            .ID_BITS    (ID_BITS),
            .TIMER_BITS (TIMER_BITS)
        ) u_slot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (slot_ctrl[i]),
            .req_id    (req_id),
            .lease_len (lease_len),
            .stat      (slot_stat[i])
        );
    end

    // Status of the addressed slot and the answer code.
    logic        sel_held;
    logic        sel_match;
    lst_status_t status;

    always_comb begin
        sel_held  = 1'b0;
        sel_match = 1'b0;
        for (int i = 0; i < NUM_TYPES; i++) begin
            if (32'(lock_type) == 32'(i + 1)) begin
                sel_held  = slot_stat[i].held;
                sel_match = slot_stat[i].owner_match;
            end
        end
        if (!type_valid) begin
            status = ST_INVALID;
        end else if (cmd == CMD_ACQUIRE) begin
            status = sel_held ? ST_BUSY : ST_OK;
        end else begin
            status = sel_match ? ST_OK : ST_NOT_OWNER;
        end
    end

    // Result register
    logic               m_valid_reg, m_valid_next;
    lst_status_t        status_reg;
    logic [TYPE_W-1:0]  echo_type_reg;
    logic               was_acquire_reg;
    logic               has_result;

    assign has_result = (cmd == CMD_ACQUIRE) || (cmd == CMD_RELEASE);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = has_result;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && has_result) begin
            status_reg      <= status;
            echo_type_reg   <= lock_type;
            was_acquire_reg <= (cmd == CMD_ACQUIRE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W - TYPE_W){1'b0}}, echo_type_reg, status_reg};
    assign m_tuser  = was_acquire_reg;

    // Every accepted acquire or release is answered in the next cycle.
    a_answer_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && has_result |=> m_valid_reg)
        else $error("accepted request left without answer");

    // Ticks and unused commands leave the answer channel empty.
    a_no_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !has_result |=> !m_valid_reg)
        else $error("answer produced for tick or unused command");

    // An out-of-range type is answered as invalid.
    a_invalid_type: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && has_result && !type_valid |=> status_reg == ST_INVALID)
        else $error("invalid type not reported");

endmodule

// ===== verif/tb_lease_semaphore_table_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the lease semaphore table unit: directed and random lock traffic.
module tb_lease_semaphore_table_unit;
    import lst_pkg::*;

    localparam int N_LOCKS       = NUM_TYPES_DEF;
    localparam int RUN_LIMIT     = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_CYCLES  = 200;

    // One answer from the table.
    typedef struct {
        lst_status_t         status;
        logic [TYPE_W-1:0]   echo_type;
        logic                was_acquire;
    } lock_answer_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [HOLD_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;   // command[1:0], lock_type[9:2], requester_id[57:10]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;   // status[1:0], echo_type[9:2]
    logic                 m_tuser;   // was_acquire[0]

    // Predicted table state and register copies.
    logic                 lock_busy   [N_LOCKS];
    logic [REQ_ID_W-1:0]  lock_owner  [N_LOCKS];
    logic [HOLD_W-1:0]    lease_count [N_LOCKS];
    logic [HOLD_W-1:0]    cur_hold      = HOLD_RST;
    logic [HOLD_W-1:0]    cur_long_hold = LONG_HOLD_RST;
    logic [LTYPE_W-1:0]   cur_long_type = LONG_TYPE_RST;

    lock_answer_t         pending_answers[$];
    logic [REQ_ID_W-1:0]  station_ids[4];
    int                   mismatch_cnt  = 0;
    int                   cycle_cnt     = 0;
    int                   src_idle_pct  = 0;
    int                   snk_idle_pct  = 0;
    int                   hold_off_req  = 0;
    int                   hold_off_left = 0;

    lease_semaphore_table_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock with a 10 ns period.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit: a hung handshake or a missing answer ends the run here.
    initial begin
        while (cycle_cnt < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Lease length for a newly granted lock; a zero register acts as one tick.
    function automatic logic [HOLD_W-1:0] lease_length(logic [TYPE_W-1:0] lock_type);
        logic [HOLD_W-1:0] len;
        len = (cur_long_type != 0 && {1'b0, cur_long_type} == lock_type) ? cur_long_hold
                                                                         : cur_hold;
        if (len == 0) begin
            len = 1;
        end
        return len;
    endfunction

    // Update the predicted table for one request and queue the answer it yields.
    task automatic apply_request(lst_cmd_t cmd, logic [TYPE_W-1:0] lock_type,
                                 logic [REQ_ID_W-1:0] req_id);
        lock_answer_t ans;
        int           slot;
        slot = int'(lock_type) - 1;
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < N_LOCKS; i++) begin
                    if (lock_busy[i] && lease_count[i] != 0) begin
                        lease_count[i]--;
                        if (lease_count[i] == 0) begin
                            lock_busy[i]  = 1'b0;
                            lock_owner[i] = '0;
                        end
                    end
                end
            end
            CMD_ACQUIRE, CMD_RELEASE: begin
                if (lock_type == 0 || lock_type > N_LOCKS) begin
                    ans.status = ST_INVALID;
                end else if (cmd == CMD_ACQUIRE) begin
                    if (lock_busy[slot]) begin
                        ans.status = ST_BUSY;
                    end else begin
                        lock_busy[slot]   = 1'b1;
                        lock_owner[slot]  = req_id;
                        lease_count[slot] = lease_length(lock_type);
                        ans.status        = ST_OK;
                    end
                end else if (lock_owner[slot] == req_id) begin
                    // A free lock has owner zero, so releasing it with ID zero is accepted.
                    lock_busy[slot]   = 1'b0;
                    lock_owner[slot]  = '0;
                    lease_count[slot] = '0;
                    ans.status        = ST_OK;
                end else begin
                    ans.status = ST_NOT_OWNER;
                end
                ans.echo_type   = lock_type;
                ans.was_acquire = (cmd == CMD_ACQUIRE);
                pending_answers.push_back(ans);
            end
            default: begin
            end
        endcase
    endtask

    // Check each answer transaction, then predict from each request transaction.
    always @(posedge aclk) begin
        lock_answer_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected answer status %0d type %0d acquire %0b",
                             $time, m_tdata[1:0], m_tdata[9:2], m_tuser);
                    mismatch_cnt++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[1:0]);
                        mismatch_cnt++;
                    end
                    if (m_tdata[9:2] !== want.echo_type) begin
                        $display("%0t: echo_type expected %0d actual %0d",
                                 $time, want.echo_type, m_tdata[9:2]);
                        mismatch_cnt++;
                    end
                    if (m_tuser !== want.was_acquire) begin
                        $display("%0t: was_acquire expected %0b actual %0b",
                                 $time, want.was_acquire, m_tuser);
                        mismatch_cnt++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                apply_request(lst_cmd_t'(s_tdata[1:0]), s_tdata[9:2], s_tdata[57:10]);
            end
        end
    end

    // Answer side: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_off_req != 0) begin
            hold_off_left = hold_off_req;
            hold_off_req  = 0;
        end
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Offer one request, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_request(lst_cmd_t cmd, logic [TYPE_W-1:0] lock_type,
                                logic [REQ_ID_W-1:0] req_id);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - REQ_ID_W - TYPE_W - CMD_W){1'b0}}, req_id, lock_type, cmd};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    // Stop offering, let the last request reach the predictor, wait for every answer,
    // then let the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register and mirror it in the predictor; the block is idle here.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [HOLD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_HOLD_TICKS:      cur_hold      = value;
            REG_LONG_HOLD_TICKS: cur_long_hold = value;
            REG_LONG_HOLD_TYPE:  cur_long_type = value[LTYPE_W-1:0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic write_lease_regs(logic [HOLD_W-1:0] hold, logic [HOLD_W-1:0] long_hold,
                                    logic [LTYPE_W-1:0] long_type);
        cfg_write(REG_HOLD_TICKS, hold);
        cfg_write(REG_LONG_HOLD_TICKS, long_hold);
        cfg_write(REG_LONG_HOLD_TYPE, HOLD_W'(long_type));
        cfg_wr_en <= 1'b0;
    endtask

    // Random request: mostly valid types and known station IDs so locks get reused.
    task automatic send_random_request();
        int                  roll;
        lst_cmd_t            cmd;
        logic [TYPE_W-1:0]   lock_type;
        logic [REQ_ID_W-1:0] req_id;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            cmd = CMD_ACQUIRE;
        end else if (roll < 65) begin
            cmd = CMD_RELEASE;
        end else if (roll < 95) begin
            cmd = CMD_TICK;
        end else begin
            cmd = CMD_NONE;
        end
        if ($urandom_range(0, 99) < 88) begin
            lock_type = TYPE_W'($urandom_range(1, N_LOCKS));
        end else begin
            lock_type = TYPE_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 85) begin
            req_id = station_ids[$urandom_range(0, 3)];
        end else begin
            req_id = REQ_ID_W'({$urandom, $urandom});
        end
        send_request(cmd, lock_type, req_id);
    endtask

    // Out-of-range types, the unused command and a tick on an empty table.
    task automatic test_invalid_types();
        send_request(CMD_ACQUIRE, 8'd0, station_ids[2]);
        send_request(CMD_RELEASE, TYPE_W'(N_LOCKS + 1), station_ids[0]);
        send_request(CMD_ACQUIRE, 8'd255, station_ids[1]);
        send_request(CMD_RELEASE, 8'd128, station_ids[3]);
        send_request(CMD_NONE, 8'd1, station_ids[1]);
        send_request(CMD_TICK, 8'd0, station_ids[0]);
        wait_idle();
    endtask

    // Grant, busy, owner checks, and release of a free lock.
    task automatic test_acquire_release();
        send_request(CMD_ACQUIRE, 8'd1, station_ids[1]);
        send_request(CMD_ACQUIRE, 8'd1, station_ids[2]);
        send_request(CMD_RELEASE, 8'd1, station_ids[2]);
        send_request(CMD_RELEASE, 8'd1, station_ids[1]);
        send_request(CMD_RELEASE, 8'd2, station_ids[0]);
        send_request(CMD_RELEASE, 8'd2, station_ids[3]);
        send_request(CMD_ACQUIRE, TYPE_W'(N_LOCKS), station_ids[0]);
        send_request(CMD_RELEASE, TYPE_W'(N_LOCKS), station_ids[0]);
        wait_idle();
    endtask

    // A zero normal lease acts as one tick; the long type outlives it.
    task automatic test_lease_expiry();
        write_lease_regs(0, 4, 3);
        send_request(CMD_ACQUIRE, 8'd2, station_ids[2]);
        send_request(CMD_ACQUIRE, 8'd3, station_ids[3]);
        send_request(CMD_TICK, 8'd0, station_ids[0]);
        send_request(CMD_ACQUIRE, 8'd2, station_ids[3]);
        send_request(CMD_ACQUIRE, 8'd3, station_ids[2]);
        repeat (3) send_request(CMD_TICK, 8'd5, station_ids[1]);
        send_request(CMD_ACQUIRE, 8'd3, station_ids[2]);
        send_request(CMD_RELEASE, 8'd3, station_ids[2]);
        wait_idle();
    endtask

    // Answers held off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        hold_off_req = STALL_CYCLES;
        repeat (60) send_random_request();
        wait_idle();
    endtask

    // One register setting followed by random traffic.
    task automatic test_random_phase(logic [HOLD_W-1:0] hold, logic [HOLD_W-1:0] long_hold,
                                     logic [LTYPE_W-1:0] long_type, int n_items);
        write_lease_regs(hold, long_hold, long_type);
        repeat (n_items) send_random_request();
        wait_idle();
    endtask

    // Test sequence.
    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_HOLD_TICKS;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        for (int i = 0; i < N_LOCKS; i++) begin
            lock_busy[i]   = 1'b0;
            lock_owner[i]  = '0;
            lease_count[i] = '0;
        end
        station_ids[0] = '0;
        station_ids[1] = '1;
        station_ids[2] = REQ_ID_W'({$urandom, $urandom});
        station_ids[3] = REQ_ID_W'({$urandom, $urandom});
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_invalid_types();
        test_acquire_release();
        test_lease_expiry();

        src_idle_pct = 35;
        snk_idle_pct = 56;
        test_random_phase(6, 30, 2, 215);
        test_random_phase(262143, 1, LTYPE_W'(N_LOCKS), 215);

        src_idle_pct = 56;
        snk_idle_pct = 35;
        test_random_phase(1, 262143, 64, 215);
        test_random_phase(12, 3, 0, 215);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_backpressure();
        test_random_phase(3, 20, 5, 215);
        test_random_phase(8, 8, LTYPE_W'(N_LOCKS + 1), 215);

        if (mismatch_cnt == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
